// ===== rtl/pfam_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator package
// Sizes, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pfam_pkg;

   // Physical frames, directories and entries per directory
   localparam int FRAME_COUNT = 32;
   localparam int DIR_COUNT   = 4;
   localparam int DIR_ENTRIES = 1024;

   localparam int FRAME_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CMD_W     = 2;
   localparam int DIR_W     = 2;
   localparam int PAGE_W    = 10;
   localparam int AMOUNT_W  = 11;
   localparam int COUNT_W   = 11;
   localparam int ENTRY_W   = 12;
   localparam int MEM_DEPTH = (1 << DIR_W) * DIR_ENTRIES;
   localparam int MEM_AW    = DIR_W + PAGE_W;

   // Stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   // Directory entry layout
   localparam int ENTRY_PRESENT_BIT = 10;
   localparam int ENTRY_USER_RW_BIT = 11;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } pfam_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture request, launch directory read
      logic commit;  // evaluate, update state, fill result register
   } pfam_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free;  // result register empty or drained this cycle
   } pfam_status_type;

endpackage

// ===== rtl/pfam_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Two-state sequencer: take a transaction, then commit it once the result
// register can accept the answer.
// ----------------------------------------------------------------------------
module pfam_ctrl
   import pfam_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  pfam_status_type status,
   output pfam_cmd_type    cmd
);

   pfam_state_type state_ff;
   pfam_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pfam_datapath.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Frame used map, free counter, first-free encoder, directory entry memory
// and the result register.
// ----------------------------------------------------------------------------
module pfam_datapath
   import pfam_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  pfam_cmd_type          cmd,
   output pfam_status_type       status,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [DIR_W-1:0]      req_directory_index,
   input  logic [PAGE_W-1:0]     req_virtual_page,
   input  logic [AMOUNT_W-1:0]   req_request_amount,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_ok,
   output logic [PAGE_W-1:0]     rsp_frame_index,
   output logic [COUNT_W-1:0]    rsp_free_count
);

   // Captured request
   logic [CMD_W-1:0]    cmd_ff;
   logic [DIR_W-1:0]    dir_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   logic [ENTRY_W-1:0]  entry_rd_ff;

   // Allocator state
   logic [FRAME_COUNT-1:0] used_map_ff;
   logic [FRAME_COUNT-1:0] used_map_in;
   logic [COUNT_W-1:0]     frames_free_ff;
   logic [COUNT_W-1:0]     frames_free_in;
   logic [FRAME_W-1:0]     first_free_ff;
   logic [FRAME_W-1:0]     first_free_in;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_ok_ff;
   logic [PAGE_W-1:0]   rsp_frame_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // Commit evaluation
   logic                dir_ok;
   logic                alloc_ok;
   logic                free_ok;
   logic                result_ok;
   logic [PAGE_W-1:0]   entry_frame;
   logic [PAGE_W-1:0]   result_frame;
   logic [ENTRY_W-1:0]  new_entry;
   logic                mem_we;

   logic [ENTRY_W-1:0] dir_mem [MEM_DEPTH];

   // Lowest free frame, registered ahead of the commit cycle
   always_comb begin
      first_free_in = '0;
      for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
         if (!used_map_ff[i]) begin
            first_free_in = FRAME_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      first_free_ff <= first_free_in;
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_command;
         dir_ff    <= req_directory_index;
         page_ff   <= req_virtual_page;
         amount_ff <= req_request_amount;
      end
   end

   // Directory entry memory: read at capture, write on a successful allocate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         entry_rd_ff <= dir_mem[{req_directory_index, req_virtual_page}];
      end
      if (mem_we) begin
         dir_mem[{dir_ff, page_ff}] <= new_entry;
      end
   end

   // Command evaluation
   always_comb begin
      dir_ok      = 32'(dir_ff) < DIR_COUNT;
      entry_frame = entry_rd_ff[PAGE_W-1:0];
      alloc_ok    = (cmd_ff == CMD_ALLOC) && dir_ok && (frames_free_ff != '0);
      free_ok     = (cmd_ff == CMD_FREE) && dir_ok
                    && entry_rd_ff[ENTRY_PRESENT_BIT]
                    && (32'(entry_frame) < FRAME_COUNT)
                    && used_map_ff[entry_frame[FRAME_W-1:0]];
      new_entry   = '0;
      new_entry[PAGE_W-1:0]         = PAGE_W'(first_free_ff);
      new_entry[ENTRY_PRESENT_BIT]  = 1'b1;
      new_entry[ENTRY_USER_RW_BIT]  = 1'b1;
      mem_we      = cmd.commit && alloc_ok;

      used_map_in    = used_map_ff;
      frames_free_in = frames_free_ff;
      result_ok      = 1'b0;
      result_frame   = '0;
      priority if (cmd_ff == CMD_CHECK) begin
         result_ok = 32'(frames_free_ff) >= 32'(amount_ff);
      end else if (alloc_ok) begin
         used_map_in[first_free_ff] = 1'b1;
         frames_free_in = frames_free_ff - COUNT_W'(1);
         result_ok      = 1'b1;
         result_frame   = PAGE_W'(first_free_ff);
      end else if (free_ok) begin
         used_map_in[entry_frame[FRAME_W-1:0]] = 1'b0;
         frames_free_in = frames_free_ff + COUNT_W'(1);
         result_ok      = 1'b1;
         result_frame   = entry_frame;
      end else begin
         result_ok = 1'b0;
      end
   end

   // Allocator state and result valid
   always_comb begin
      status.slot_free = !rsp_valid_ff || rsp_tready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_map_ff    <= FRAME_COUNT'(1);
         frames_free_ff <= COUNT_W'(FRAME_COUNT - 1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.commit) begin
            used_map_ff    <= used_map_in;
            frames_free_ff <= frames_free_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ok_ff    <= result_ok;
         rsp_frame_ff <= result_frame;
         rsp_count_ff <= frames_free_in;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_free_count  = rsp_count_ff;

`ifndef SYNTHESIS
   // Free counter tracks the number of clear bits in the used map
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      32'($countones(~used_map_ff)) == 32'(frames_free_ff))
      else $error("free count disagrees with used map");

   // Frame 0 stays reserved
   a_frame0_reserved: assert property (@(posedge clock) disable iff (reset)
      used_map_ff[0])
      else $error("frame 0 released");

   // A new result appears only after a commit
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid without commit");

   // A commit never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> !$past(cmd.commit))
      else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/page_frame_allocator_mapper_top.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator and mapper, top level
// Stream front end joining the sequencer and the allocator datapath.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. A
// request is handled in two steps: capture, which also reads the directory
// entry memory, then commit, which evaluates the command, updates the used
// map, free count and entry, and loads the result register. The next
// request is taken in the cycle after a commit, while the previous response
// may still wait in the result register; a stalled response holds the
// commit back. The entry memory has no reset; freeing a page never mapped
// is not allowed. Frame 0 is reserved at reset.
module page_frame_allocator_mapper_top
   import pfam_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // [1:0] command, [3:2] directory_index, [13:4] virtual_page,
   // [24:14] request_amount, [31:25] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] ok, [10:1] frame_index, [21:11] free_count, [23:22] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   pfam_cmd_type    cmd;
   pfam_status_type status;

   logic                rsp_ok;
   logic [PAGE_W-1:0]   rsp_frame_index;
   logic [COUNT_W-1:0]  rsp_free_count;

   // Sequencer
   pfam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Allocator datapath
   pfam_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_tdata[1:0]),
      .req_directory_index (req_tdata[3:2]),
      .req_virtual_page    (req_tdata[13:4]),
      .req_request_amount  (req_tdata[24:14]),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_ok              (rsp_ok),
      .rsp_frame_index     (rsp_frame_index),
      .rsp_free_count      (rsp_free_count)
   );

   // Response packing
   assign rsp_tdata = {2'b00, rsp_free_count, rsp_frame_index, rsp_ok};

endmodule
